### design/tcc_pkg.sv
// Shared package for the text console cursor engine.
// Holds action and control character codes, default geometry and the
// command and status structs passed between controller and datapath.
package tcc_pkg;

  // Default screen geometry
  localparam int DEFAULT_COLUMNS = 80;
  localparam int DEFAULT_ROWS    = 25;

  // Cursor and target coordinate width
  localparam int COORD_W = 8;

  // Item actions
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_MOVE  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  // Control characters
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Tab stops fall on multiples of four
  localparam logic [7:0] TAB_MASK = 8'hFC;

  // Fill attribute after reset
  localparam logic [7:0] FILL_ATTR_RESET = 8'h07;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;      // capture the incoming beat
    logic decode;      // form the cell address
    logic act;         // carry out the action, start any sweep
    logic sweep_step;  // one step of a scroll or clear sweep
    logic load_out;    // load the result register
  } tcc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic needs_sweep; // the action scrolls or clears the screen
    logic sweep_last;  // the current sweep step is the final one
    logic out_free;    // the result register can take a new beat
  } tcc_status_t;

endpackage

### design/tcc_item_if.sv
// Input channel of the text console cursor engine: valid/ready and the
// item payload. Stands alone, no package needed.
interface tcc_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] char_code;
  logic [3:0] foreground;
  logic [3:0] background;
  logic [7:0] target_row;
  logic [7:0] target_column;

  modport source (
    output valid, action, char_code, foreground, background, target_row, target_column,
    input  ready
  );

  modport sink (
    input  valid, action, char_code, foreground, background, target_row, target_column,
    output ready
  );
endinterface

### design/tcc_result_if.sv
// Result channel of the text console cursor engine: valid/ready and the
// result payload. Stands alone, no package needed.
interface tcc_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  cursor_row;
  logic [7:0]  cursor_column;
  logic [15:0] cursor_location;
  logic [15:0] cell_data;
  logic        position_rejected;
  logic        did_scroll;

  modport source (
    output valid, cursor_row, cursor_column, cursor_location, cell_data,
           position_rejected, did_scroll,
    input  ready
  );

  modport sink (
    input  valid, cursor_row, cursor_column, cursor_location, cell_data,
           position_rejected, did_scroll,
    output ready
  );
endinterface

### design/tcc_ctrl.sv
// Controller state machine of the text console cursor engine.
// Sequences accept, decode, action, sweep and result load; uses tcc_pkg.
module tcc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcc_pkg::tcc_status_t status,
  output tcc_pkg::tcc_cmd_t    cmd
);
  import tcc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_ACT    = 3'd2;
  localparam logic [2:0] S_SWEEP  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // Issue commands and pick the next state
  always_comb begin
    state_next     = state;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_ACT;
      end
      S_ACT: begin
        cmd.act    = 1'b1;
        state_next = status.needs_sweep ? S_SWEEP : S_DONE;
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (status.sweep_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.load_out = status.out_free;
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### design/tcc_datapath.sv
// Datapath of the text console cursor engine: item register, cursor,
// screen memory with its write stage, sweep counter and result register.
// Uses tcc_pkg; driven by tcc_ctrl commands.
module tcc_datapath #(
  parameter int COLUMNS = tcc_pkg::DEFAULT_COLUMNS,
  parameter int ROWS    = tcc_pkg::DEFAULT_ROWS
) (
  input  logic                clk,
  input  logic                rst,
  input  tcc_pkg::tcc_cmd_t   cmd,
  output tcc_pkg::tcc_status_t status,
  input  logic                write_enable,
  input  logic [7:0]          write_data,
  input  logic [1:0]          in_action,
  input  logic [7:0]          in_char_code,
  input  logic [3:0]          in_foreground,
  input  logic [3:0]          in_background,
  input  logic [7:0]          in_target_row,
  input  logic [7:0]          in_target_column,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_cursor_row,
  output logic [7:0]          out_cursor_column,
  output logic [15:0]         out_cursor_location,
  output logic [15:0]         out_cell_data,
  output logic                out_position_rejected,
  output logic                out_did_scroll
);
  import tcc_pkg::*;

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int SWEEP_W    = $clog2(CELL_COUNT + COLUMNS);

  localparam logic [COORD_W:0]   COLS_X     = (COORD_W + 1)'(COLUMNS);
  localparam logic [COORD_W:0]   ROWS_X     = (COORD_W + 1)'(ROWS);
  localparam logic [15:0]        COLS_16    = 16'(COLUMNS);
  localparam logic [SWEEP_W-1:0] SWEEP_COLS = SWEEP_W'(COLUMNS);
  localparam logic [SWEEP_W-1:0] SWEEP_CELLS = SWEEP_W'(CELL_COUNT);
  localparam logic [SWEEP_W-1:0] CLEAR_LAST = SWEEP_W'(CELL_COUNT - 1);
  localparam logic [SWEEP_W-1:0] SCROLL_LAST = SWEEP_W'(CELL_COUNT + COLUMNS - 1);

  // Configuration
  logic [7:0] fill_attribute;

  // Item register
  logic [1:0]         item_action;
  logic [7:0]         item_char;
  logic [7:0]         item_attr;
  logic [COORD_W-1:0] item_row;
  logic [COORD_W-1:0] item_column;

  // Cursor and per-item results
  logic [COORD_W-1:0] cursor_row;
  logic [COORD_W-1:0] cursor_column;
  logic [ADDR_W-1:0]  cell_addr;
  logic               item_rejected;
  logic               item_scrolled;

  // Sweep and write stage
  logic [SWEEP_W-1:0] sweep;
  logic               sweep_clear;
  logic               wr_en;
  logic               wr_copy;
  logic [ADDR_W-1:0]  wr_addr;
  logic [15:0]        wr_data;

  // Memory read port
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [15:0]        rd_data;
  logic [15:0]        screen_cells [CELL_COUNT];

  // Decoded controls
  logic               is_write;
  logic               is_lf;
  logic               is_cr;
  logic               is_tab;
  logic               is_bs;
  logic               printable;
  logic               on_screen;
  logic [COORD_W:0]   col_inc;
  logic [COORD_W:0]   tab_col;
  logic               last_row;
  logic               wants_nl;
  logic               wants_scroll;
  logic               copy_read;
  logic [COORD_W-1:0] src_row;
  logic [COORD_W-1:0] src_column;
  logic [15:0]        src_index;
  logic [15:0]        blank;

  // Classify the held item against the current cursor
  always_comb begin
    is_write   = (item_action == ACT_WRITE);
    is_lf      = (item_char == CH_LF);
    is_cr      = (item_char == CH_CR);
    is_tab     = (item_char == CH_TAB);
    is_bs      = (item_char == CH_BS);
    printable  = !(is_lf || is_cr || is_tab || is_bs);
    on_screen  = ({1'b0, item_row} < ROWS_X) && ({1'b0, item_column} < COLS_X);
    col_inc    = {1'b0, cursor_column} + (COORD_W + 1)'(1);
    tab_col    = ({1'b0, cursor_column} + (COORD_W + 1)'(4)) & {1'b0, TAB_MASK};
    last_row   = ({1'b0, cursor_row} + (COORD_W + 1)'(1)) >= ROWS_X;
    wants_nl   = is_write && (is_lf || (is_tab && (tab_col >= COLS_X)) ||
                              (printable && (col_inc >= COLS_X)));
    wants_scroll = wants_nl && last_row;
    blank      = {fill_attribute, CH_SPACE};
  end

  assign status.needs_sweep = wants_scroll || (item_action == ACT_CLEAR);
  assign status.sweep_last  = sweep == (sweep_clear ? CLEAR_LAST : SCROLL_LAST);
  assign status.out_free    = !out_valid || out_ready;

  // Cell address of the read target or of the cursor
  always_comb begin
    src_row    = (item_action == ACT_READ) ? item_row    : cursor_row;
    src_column = (item_action == ACT_READ) ? item_column : cursor_column;
    src_index  = {8'd0, src_row} * COLS_16 + {8'd0, src_column};
  end

  // Read port: cell read on the action step, copy source on the copy steps of a scroll
  always_comb begin
    copy_read = cmd.sweep_step && !sweep_clear && (sweep < SWEEP_CELLS);
    rd_en     = (cmd.act && (item_action == ACT_READ) && on_screen) || copy_read;
    rd_addr   = copy_read ? sweep[ADDR_W-1:0] : cell_addr;
  end

  // Screen memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      screen_cells[wr_addr] <= wr_copy ? rd_data : wr_data;
    end
    if (rd_en) begin
      rd_data <= screen_cells[rd_addr];
    end
  end

  // Hold the fill attribute
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_attribute <= FILL_ATTR_RESET;
    end else if (write_enable) begin
      fill_attribute <= write_data;
    end
  end

  // Capture the item and form the cell address
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_action <= in_action;
      item_char   <= in_char_code;
      item_attr   <= {in_background, in_foreground};
      item_row    <= in_target_row;
      item_column <= in_target_column;
    end
    if (cmd.decode) begin
      cell_addr <= src_index[ADDR_W-1:0];
    end
  end

  // Advance the cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_row    <= '0;
      cursor_column <= '0;
    end else if (cmd.act) begin
      unique case (item_action)
        ACT_WRITE: begin
          if (wants_nl) begin
            cursor_column <= '0;
            if (!last_row) begin
              cursor_row <= cursor_row + 1'b1;
            end
          end else if (is_cr) begin
            cursor_column <= '0;
          end else if (is_tab) begin
            cursor_column <= tab_col[COORD_W-1:0];
          end else if (is_bs) begin
            if (cursor_column != '0) begin
              cursor_column <= cursor_column - 1'b1;
            end
          end else begin
            cursor_column <= col_inc[COORD_W-1:0];
          end
        end
        ACT_MOVE: begin
          if (on_screen) begin
            cursor_row    <= item_row;
            cursor_column <= item_column;
          end
        end
        ACT_CLEAR: begin
          cursor_row    <= '0;
          cursor_column <= '0;
        end
        ACT_READ: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Record the per-item flags
  always_ff @(posedge clk) begin
    if (cmd.act) begin
      item_scrolled <= wants_scroll;
      item_rejected <= ((item_action == ACT_MOVE) || (item_action == ACT_READ)) && !on_screen;
    end
  end

  // Write stage control: a printable store or one sweep write per step
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_en <= 1'b0;
    end else begin
      wr_en <= (cmd.act && is_write && printable) || cmd.sweep_step;
    end
  end

  // Write stage payload and sweep counter
  always_ff @(posedge clk) begin
    if (cmd.act) begin
      wr_copy     <= 1'b0;
      wr_addr     <= cell_addr;
      wr_data     <= {item_attr, item_char};
      sweep_clear <= (item_action == ACT_CLEAR);
      sweep       <= (item_action == ACT_CLEAR) ? '0 : SWEEP_COLS;
    end else if (cmd.sweep_step) begin
      sweep   <= sweep + 1'b1;
      wr_copy <= copy_read;
      wr_data <= blank;
      wr_addr <= sweep_clear ? sweep[ADDR_W-1:0] : ADDR_W'(sweep - SWEEP_COLS);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_cursor_row        <= cursor_row;
      out_cursor_column     <= cursor_column;
      out_cursor_location   <= {8'd0, cursor_row} * COLS_16 + {8'd0, cursor_column};
      out_cell_data         <= ((item_action == ACT_READ) && !item_rejected) ? rd_data : '0;
      out_position_rejected <= item_rejected;
      out_did_scroll        <= item_scrolled;
    end
  end

endmodule

### design/text_console_cursor_engine.sv
// Text console cursor engine: a ROWS x COLUMNS screen of 16-bit cells
// (character low byte, attribute high byte) and a cursor.
// Channels: item (sink) takes action, char_code, foreground, background,
// target_row and target_column; result (source) returns the cursor, its
// linear location row * COLUMNS + column, the cell read, a rejected flag
// and a scroll flag. Each beat moves on a rising edge with valid and ready
// high. The fill attribute is written by write_enable and write_data; the
// user must write it only while the block is idle, which the block itself
// does not enforce; it resets to 7. Items are taken one at a time: each
// goes through the decode, action, any sweep and result load steps of the
// controller before the next is accepted. A write that scrolls adds a sweep
// (copy rows up, then fill the bottom row), and clear screen adds a sweep
// over every cell, both through the single write port of the screen memory.
// Reset clears the cursor to row 0, column 0 and empties the result
// register; screen contents are undefined until written.
// A stalled receiver holds the result; the next item is still accepted and
// worked on, and waits for the result register to free up before loading.
// Uses tcc_pkg, tcc_ctrl, tcc_datapath and both channel interfaces.
module text_console_cursor_engine #(
  parameter int COLUMNS = tcc_pkg::DEFAULT_COLUMNS,
  parameter int ROWS    = tcc_pkg::DEFAULT_ROWS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          write_enable,
  input  logic [7:0]    write_data,
  tcc_item_if.sink      item,
  tcc_result_if.source  result
);
  import tcc_pkg::*;

  tcc_cmd_t    cmd;
  tcc_status_t status;

  // Sequence the item through its steps
  tcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold cursor, screen and result
  tcc_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk                   (clk),
    .rst                   (rst),
    .cmd                   (cmd),
    .status                (status),
    .write_enable          (write_enable),
    .write_data            (write_data),
    .in_action             (item.action),
    .in_char_code          (item.char_code),
    .in_foreground         (item.foreground),
    .in_background         (item.background),
    .in_target_row         (item.target_row),
    .in_target_column      (item.target_column),
    .out_valid             (result.valid),
    .out_ready             (result.ready),
    .out_cursor_row        (result.cursor_row),
    .out_cursor_column     (result.cursor_column),
    .out_cursor_location   (result.cursor_location),
    .out_cell_data         (result.cell_data),
    .out_position_rejected (result.position_rejected),
    .out_did_scroll        (result.did_scroll)
  );

endmodule

### design/tcc_checker.sv
// Port checker for the text console cursor engine, bound to the top level.
// Depends on tcc_pkg for default geometry only.
module tcc_checker #(
  parameter int COLUMNS = tcc_pkg::DEFAULT_COLUMNS,
  parameter int ROWS    = tcc_pkg::DEFAULT_ROWS
) (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [7:0]  result_cursor_row,
  input logic [7:0]  result_cursor_column,
  input logic [15:0] result_cursor_location,
  input logic        result_position_rejected,
  input logic        result_did_scroll
);

  // Cursor always stays on screen
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_cursor_row < ROWS) && (result_cursor_column < COLUMNS))
    else $error("cursor off screen");

  // Location matches the reported cursor
  a_location: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_cursor_location ==
      ({8'd0, result_cursor_row} * 16'(COLUMNS) + {8'd0, result_cursor_column}))
    else $error("cursor location mismatch");

  // Only writes scroll and only moves and reads are rejected, so both flags never show on one result
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result_position_rejected && result_did_scroll))
    else $error("scroll and reject on one result");

  // One item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("item accepted while busy");

  // Stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> result_valid && $stable(result_cursor_location))
    else $error("stalled result changed");

endmodule

bind text_console_cursor_engine tcc_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcc_checker (
  .clk                      (clk),
  .rst                      (rst),
  .item_valid               (item.valid),
  .item_ready               (item.ready),
  .result_valid             (result.valid),
  .result_ready             (result.ready),
  .result_cursor_row        (result.cursor_row),
  .result_cursor_column     (result.cursor_column),
  .result_cursor_location   (result.cursor_location),
  .result_position_rejected (result.position_rejected),
  .result_did_scroll        (result.did_scroll)
);

### sim/tb.sv
// Self-checking testbench for text_console_cursor_engine: a shadow screen
// predicts every result beat and checks it as it comes out.
// Depends on tcc_pkg, tcc_item_if, tcc_result_if and the engine RTL.
import tcc_pkg::*;

localparam int SCR_COLS   = DEFAULT_COLUMNS;
localparam int SCR_ROWS   = DEFAULT_ROWS;
localparam int CELL_COUNT = SCR_COLS * SCR_ROWS;

typedef struct packed {
  logic [1:0] action;
  logic [7:0] char_code;
  logic [3:0] foreground;
  logic [3:0] background;
  logic [7:0] target_row;
  logic [7:0] target_column;
} console_item_t;

typedef struct packed {
  logic [7:0]  cursor_row;
  logic [7:0]  cursor_column;
  logic [15:0] cursor_location;
  logic [15:0] cell_data;
  logic        position_rejected;
  logic        did_scroll;
} cursor_report_t;

// Shadow of the screen and cursor; predicts one report per item
class screen_shadow;
  logic [15:0]    cells [CELL_COUNT];
  bit             known [CELL_COUNT];
  logic [7:0]     cur_row;
  logic [7:0]     cur_col;
  logic [7:0]     fill_attr;
  cursor_report_t pending_reports [$];
  int             mismatches;
  int             checked;
  int             scrolls;
  int             clears;
  int             rejects;

  function new();
    cur_row   = '0;
    cur_col   = '0;
    fill_attr = FILL_ATTR_RESET;
    foreach (known[i]) known[i] = 1'b0;
  endfunction

  function logic [15:0] blank_cell();
    return {fill_attr, CH_SPACE};
  endfunction

  function bit is_known(int r, int c);
    return known[r * SCR_COLS + c];
  endfunction

  function int pending();
    return pending_reports.size();
  endfunction

  // Go to column 0 of the next row; scroll up when on the bottom row
  function bit next_line();
    int i;
    cur_col = '0;
    if (int'(cur_row) + 1 >= SCR_ROWS) begin
      for (i = 0; i < CELL_COUNT - SCR_COLS; i++) begin
        cells[i] = cells[i + SCR_COLS];
        known[i] = known[i + SCR_COLS];
      end
      for (i = CELL_COUNT - SCR_COLS; i < CELL_COUNT; i++) begin
        cells[i] = blank_cell();
        known[i] = 1'b1;
      end
      cur_row = 8'(SCR_ROWS - 1);
      scrolls++;
      return 1'b1;
    end
    cur_row = cur_row + 8'd1;
    return 1'b0;
  endfunction

  // Apply one accepted item and queue the report it should produce
  function void take_item(console_item_t it);
    cursor_report_t rep;
    int             nx;
    int             idx;
    bit             on_screen;
    rep = '0;
    on_screen = (int'(it.target_row) < SCR_ROWS) && (int'(it.target_column) < SCR_COLS);
    case (it.action)
      ACT_WRITE: begin
        if (it.char_code == CH_LF) begin
          rep.did_scroll = next_line();
        end else if (it.char_code == CH_CR) begin
          cur_col = '0;
        end else if (it.char_code == CH_TAB) begin
          nx = (int'(cur_col) + 4) & int'(TAB_MASK);
          if (nx >= SCR_COLS) rep.did_scroll = next_line();
          else cur_col = 8'(nx);
        end else if (it.char_code == CH_BS) begin
          if (cur_col > 0) cur_col = cur_col - 8'd1;
        end else begin
          idx = int'(cur_row) * SCR_COLS + int'(cur_col);
          cells[idx] = {it.background, it.foreground, it.char_code};
          known[idx] = 1'b1;
          if (int'(cur_col) + 1 >= SCR_COLS) rep.did_scroll = next_line();
          else cur_col = cur_col + 8'd1;
        end
      end
      ACT_MOVE: begin
        if (on_screen) begin
          cur_row = it.target_row;
          cur_col = it.target_column;
        end else begin
          rep.position_rejected = 1'b1;
          rejects++;
        end
      end
      ACT_CLEAR: begin
        foreach (cells[i]) begin
          cells[i] = blank_cell();
          known[i] = 1'b1;
        end
        cur_row = '0;
        cur_col = '0;
        clears++;
      end
      default: begin
        if (on_screen) begin
          rep.cell_data = cells[int'(it.target_row) * SCR_COLS + int'(it.target_column)];
        end else begin
          rep.position_rejected = 1'b1;
          rejects++;
        end
      end
    endcase
    rep.cursor_row      = cur_row;
    rep.cursor_column   = cur_col;
    rep.cursor_location = 16'(int'(cur_row) * SCR_COLS + int'(cur_col));
    pending_reports.push_back(rep);
  endfunction

  function void compare_field(string label, logic [15:0] want, logic [15:0] seen);
    if (seen !== want) begin
      $display("%0t mismatch on %s: expected 0x%h, got 0x%h", $time, label, want, seen);
      mismatches++;
    end
  endfunction

  // Check one result beat against the oldest queued report
  function void check_report(cursor_report_t seen);
    cursor_report_t want;
    if (pending_reports.size() == 0) begin
      $display("%0t unexpected result beat: expected none, got 0x%h", $time, seen);
      mismatches++;
      return;
    end
    want = pending_reports.pop_front();
    checked++;
    compare_field("cursor_row", 16'(want.cursor_row), 16'(seen.cursor_row));
    compare_field("cursor_column", 16'(want.cursor_column), 16'(seen.cursor_column));
    compare_field("cursor_location", want.cursor_location, seen.cursor_location);
    compare_field("cell_data", want.cell_data, seen.cell_data);
    compare_field("position_rejected", 16'(want.position_rejected),
                  16'(seen.position_rejected));
    compare_field("did_scroll", 16'(want.did_scroll), 16'(seen.did_scroll));
  endfunction
endclass

module tb;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 400;
  localparam int PHASE_ITEMS    = 480;

  logic       clk;
  logic       rst;
  logic       write_enable;
  logic [7:0] write_data;

  tcc_item_if   item_ch ();
  tcc_result_if res_ch ();

  text_console_cursor_engine dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_data   (write_data),
    .item         (item_ch),
    .result       (res_ch)
  );

  screen_shadow shadow = new();

  int send_idle_pct;
  int recv_stall_pct;
  int hold_token;
  int hold_seen;
  int hold_left;
  int idle_cycles;
  int items_sent;
  int fill_settings;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: check each beat, then choose ready for the next edge
  always @(posedge clk) begin : result_sink
    cursor_report_t seen;
    if (!rst && res_ch.valid && res_ch.ready) begin
      seen = {res_ch.cursor_row, res_ch.cursor_column, res_ch.cursor_location,
              res_ch.cell_data, res_ch.position_rejected, res_ch.did_scroll};
      shadow.check_report(seen);
    end
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen    <= hold_token;
      hold_left    <= LONG_HOLD;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic console_item_t console_op(logic [1:0] act, logic [7:0] ch,
                                               logic [3:0] fg, logic [3:0] bg,
                                               int r, int c);
    console_item_t it;
    it.action        = act;
    it.char_code     = ch;
    it.foreground    = fg;
    it.background    = bg;
    it.target_row    = 8'(r);
    it.target_column = 8'(c);
    return it;
  endfunction

  // Mostly text with controls and moves; reads touch only known cells or fall off the screen
  function automatic console_item_t random_item();
    console_item_t it;
    int            pick;
    it.action        = ACT_WRITE;
    it.char_code     = 8'($urandom_range(255));
    it.foreground    = 4'($urandom_range(15));
    it.background    = 4'($urandom_range(15));
    it.target_row    = 8'($urandom_range(255));
    it.target_column = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 50) begin
      // printable text, controls turn up now and then
    end else if (pick < 58) begin
      it.char_code = CH_LF;
    end else if (pick < 62) begin
      it.char_code = CH_CR;
    end else if (pick < 67) begin
      it.char_code = CH_TAB;
    end else if (pick < 72) begin
      it.char_code = CH_BS;
    end else if (pick < 86) begin
      it.action = ACT_MOVE;
      if (pick >= 84) begin
        it.target_row    = 8'(SCR_ROWS - 1);
        it.target_column = 8'($urandom_range(SCR_COLS - 1));
      end else if ($urandom_range(4) != 0) begin
        it.target_row    = 8'($urandom_range(SCR_ROWS - 1));
        it.target_column = 8'($urandom_range(SCR_COLS - 1));
      end
    end else if (pick < 87) begin
      it.action = ACT_CLEAR;
    end else begin
      it.action = ACT_READ;
      if ($urandom_range(4) != 0) begin
        it.target_row    = 8'($urandom_range(SCR_ROWS - 1));
        it.target_column = 8'($urandom_range(SCR_COLS - 1));
      end
      if (int'(it.target_row) < SCR_ROWS && int'(it.target_column) < SCR_COLS &&
          !shadow.is_known(int'(it.target_row), int'(it.target_column)))
        it.target_row = 8'($urandom_range(255, SCR_ROWS));
    end
    return it;
  endfunction

  // Offer one item, with random idle cycles first, and hold until taken
  task automatic send_item(input console_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.action        <= it.action;
    item_ch.char_code     <= it.char_code;
    item_ch.foreground    <= it.foreground;
    item_ch.background    <= it.background;
    item_ch.target_row    <= it.target_row;
    item_ch.target_column <= it.target_column;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    shadow.take_item(it);
    items_sent++;
  endtask

  // Drop valid and wait for every queued report to come back
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (shadow.pending() != 0);
  endtask

  task automatic write_fill(input logic [7:0] value);
    write_enable <= 1'b1;
    write_data   <= value;
    @(posedge clk);
    write_enable <= 1'b0;
    shadow.fill_attr = value;
    fill_settings++;
  endtask

  task automatic run_directed();
    // off-screen reads
    send_item(console_op(ACT_READ, 8'h00, 4'h0, 4'h0, SCR_ROWS, 0));
    send_item(console_op(ACT_READ, 8'h00, 4'h0, 4'h0, 0, SCR_COLS));
    send_item(console_op(ACT_READ, 8'hFF, 4'hF, 4'hF, 255, 255));
    // extreme characters and attributes, then read them back
    send_item(console_op(ACT_WRITE, 8'h41, 4'hF, 4'hF, 0, 0));
    send_item(console_op(ACT_WRITE, 8'h00, 4'h0, 4'h0, 0, 0));
    send_item(console_op(ACT_WRITE, 8'hFF, 4'hA, 4'h5, 0, 0));
    send_item(console_op(ACT_READ, 8'h00, 4'h0, 4'h0, 0, 0));
    send_item(console_op(ACT_READ, 8'h00, 4'h0, 4'h0, 0, 2));
    // backspace down to column 0 and once more at the floor
    repeat (4) send_item(console_op(ACT_WRITE, CH_BS, 4'h0, 4'h0, 0, 0));
    send_item(console_op(ACT_WRITE, CH_TAB, 4'h0, 4'h0, 0, 0));
    send_item(console_op(ACT_WRITE, CH_CR, 4'h0, 4'h0, 0, 0));
    // tab past the last stop wraps to the next line
    send_item(console_op(ACT_MOVE, 8'h00, 4'h0, 4'h0, 3, SCR_COLS - 3));
    send_item(console_op(ACT_WRITE, CH_TAB, 4'h0, 4'h0, 0, 0));
    // printable at the last column wraps; in the corner it scrolls
    send_item(console_op(ACT_MOVE, 8'h00, 4'h0, 4'h0, 0, SCR_COLS - 1));
    send_item(console_op(ACT_WRITE, 8'h5A, 4'h2, 4'h1, 0, 0));
    send_item(console_op(ACT_MOVE, 8'h00, 4'h0, 4'h0, SCR_ROWS - 1, SCR_COLS - 1));
    send_item(console_op(ACT_WRITE, 8'h78, 4'h3, 4'h8, 0, 0));
    send_item(console_op(ACT_READ, 8'h00, 4'h0, 4'h0, SCR_ROWS - 2, SCR_COLS - 1));
    send_item(console_op(ACT_READ, 8'h00, 4'h0, 4'h0, SCR_ROWS - 1, 0));
    // line feed and tab on the bottom row both scroll
    send_item(console_op(ACT_WRITE, CH_LF, 4'h0, 4'h0, 0, 0));
    send_item(console_op(ACT_MOVE, 8'h00, 4'h0, 4'h0, SCR_ROWS - 1, SCR_COLS - 1));
    send_item(console_op(ACT_WRITE, CH_TAB, 4'h0, 4'h0, 0, 0));
    // rejected moves leave the cursor alone
    send_item(console_op(ACT_MOVE, 8'h00, 4'h0, 4'h0, SCR_ROWS, 0));
    send_item(console_op(ACT_MOVE, 8'h00, 4'h0, 4'h0, 0, SCR_COLS));
    // clear, then read blanks in the fill attribute
    send_item(console_op(ACT_CLEAR, 8'h00, 4'h0, 4'h0, 0, 0));
    send_item(console_op(ACT_READ, 8'h00, 4'h0, 4'h0, SCR_ROWS - 1, SCR_COLS - 1));
    drain_results();
  endtask

  task automatic run_phase(input int count, input int idle_pct, input int stall_pct,
                           input logic [7:0] fill, input bit pressure);
    write_fill(fill);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      // long receiver hold while items keep coming, later a full drain
      if (pressure && n == count / 4) hold_token <= hold_token + 1;
      if (pressure && n == count / 2) drain_results();
      send_item(random_item());
    end
    drain_results();
  endtask

  initial begin : stimulus
    rst                   <= 1'b1;
    write_enable          <= 1'b0;
    write_data            <= '0;
    item_ch.valid         <= 1'b0;
    item_ch.action        <= ACT_WRITE;
    item_ch.char_code     <= '0;
    item_ch.foreground    <= '0;
    item_ch.background    <= '0;
    item_ch.target_row    <= '0;
    item_ch.target_column <= '0;
    hold_token            <= 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    write_fill(8'hFF);
    run_directed();
    run_phase(PHASE_ITEMS, 0, 0, 8'h00, 1'b0);
    run_phase(PHASE_ITEMS, 58, 0, 8'($urandom_range(255)), 1'b0);
    run_phase(PHASE_ITEMS, 0, 58, 8'h80, 1'b1);
    run_phase(PHASE_ITEMS, 10, 10, 8'($urandom_range(255)), 1'b0);

    // let any stray beat show up before the verdict
    repeat (20) @(posedge clk);
    $display("Run covered %0d items and %0d checked results under %0d fill settings,",
             items_sent, shadow.checked, fill_settings);
    $display("with %0d scrolls, %0d clears and %0d off-screen positions.",
             shadow.scrolls, shadow.clears, shadow.rejects);
    if (shadow.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
